@@ sv/assert_macros.svh @@
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ sv/bitw_pkg.sv @@
// Types and constants of the boot information tag walker.
`default_nettype none
package bitw_pkg;
  localparam int OFF_W = 21;

  localparam logic [2:0] KIND_TOTAL = 3'd0;
  localparam logic [2:0] KIND_TAG   = 3'd1;
  localparam logic [2:0] KIND_MMAP  = 3'd2;
  localparam logic [2:0] KIND_ACPI  = 3'd3;
  localparam logic [2:0] KIND_FB    = 3'd4;
  localparam logic [2:0] KIND_FINAL = 3'd5;

  localparam logic [3:0] ST_PASS    = 4'd0;
  localparam logic [3:0] ST_TOTAL   = 4'd1;
  localparam logic [3:0] ST_BOUNDS  = 4'd2;
  localparam logic [3:0] ST_MMAP    = 4'd3;
  localparam logic [3:0] ST_ACPI    = 4'd4;
  localparam logic [3:0] ST_FB      = 4'd5;
  localparam logic [3:0] ST_ENDLAST = 4'd6;
  localparam logic [3:0] ST_SMALL   = 4'd7;
  localparam logic [3:0] ST_NOEND   = 4'd8;

  localparam logic [31:0] TAG_END  = 32'd0;
  localparam logic [31:0] TAG_MMAP = 32'd6;
  localparam logic [31:0] TAG_FB   = 32'd8;
  localparam logic [31:0] TAG_RSDP1 = 32'd14;
  localparam logic [31:0] TAG_RSDP2 = 32'd15;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [63:0] value_a;
    logic [63:0] value_b;
    logic [31:0] value_c;
    logic [31:0] value_d;
    logic [7:0]  value_e;
    logic [7:0]  value_f;
    logic [3:0]  status;
    logic        last_of_run;
  } rec_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  typedef struct packed {
    logic [2:0] level;
    logic       room;
  } qstat_t;

  function automatic rec_t mk_rec(logic [2:0] kind, logic [63:0] a, logic [63:0] b,
                                  logic [31:0] c, logic [31:0] d, logic [7:0] e,
                                  logic [7:0] f, logic [3:0] st);
    rec_t r;
    r.record_kind = kind;
    r.value_a = a;
    r.value_b = b;
    r.value_c = c;
    r.value_d = d;
    r.value_e = e;
    r.value_f = f;
    r.status = st;
    r.last_of_run = 1'b0;
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/bitw_byte_if.sv @@
// Input byte channel.
`default_nettype none
interface bitw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;
  modport source (output valid, data_byte, block_start, input ready);
  modport sink (input valid, data_byte, block_start, output ready);
endinterface
`default_nettype wire

@@ sv/bitw_rec_if.sv @@
// Output record channel.
`default_nettype none
interface bitw_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [63:0] value_a;
  logic [63:0] value_b;
  logic [31:0] value_c;
  logic [31:0] value_d;
  logic [7:0]  value_e;
  logic [7:0]  value_f;
  logic [3:0]  status;
  logic        last_of_run;
  modport source (output valid, record_kind, value_a, value_b, value_c, value_d,
                  value_e, value_f, status, last_of_run, input ready);
  modport sink (input valid, record_kind, value_a, value_b, value_c, value_d,
                value_e, value_f, status, last_of_run, output ready);
endinterface
`default_nettype wire

@@ sv/bitw_core.sv @@
// Walk state and per-byte record decode.
`default_nettype none
module bitw_core
  import bitw_pkg::*;
#(
  parameter int MAX_TOTAL = 1048576
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       block_start,
  output push_t           push
);
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_WALK = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [OFF_W-1:0] byte_offset, byte_offset_next;
  logic [OFF_W-1:0] block_total, block_total_next;
  logic [OFF_W-1:0] tag_start, tag_start_next;
  logic [31:0]      tag_type, tag_type_next;
  logic [31:0]      tag_size, tag_size_next;
  logic [31:0]      entry_stride, entry_stride_next;
  logic [OFF_W-1:0] entry_start, entry_start_next;
  logic [63:0]      byte_window, byte_window_next;
  logic [63:0]      held_wide_a, held_wide_a_next;
  logic [63:0]      held_wide_b, held_wide_b_next;
  logic [31:0]      held_narrow, held_narrow_next;
  logic [1:0]       phase, phase_next;

  logic [OFF_W-1:0] b_off, b_total, b_tstart, b_estart;
  logic [31:0]      b_ttype, b_tsize, b_stride, b_hn;
  logic [63:0]      b_win, b_ha, b_hb;
  logic [31:0]      hi;
  logic [OFF_W-1:0] rel, erel;
  logic [31:0]      rel32, size_eff;
  logic [33:0]      next_tag;
  logic [33:0]      end_next;
  logic [32:0]      entry_end;
  logic [47:0]      oem;
  logic             active, done, do_end;
  logic [1:0]       n;
  rec_t             er, r0, r1;

  // Decode one byte: base state, window shift, then header or tag walk.
  always_comb begin
    b_off    = block_start ? '0 : byte_offset;
    b_total  = block_start ? '0 : block_total;
    b_tstart = block_start ? OFF_W'(8) : tag_start;
    b_ttype  = block_start ? '0 : tag_type;
    b_tsize  = block_start ? '0 : tag_size;
    b_stride = block_start ? '0 : entry_stride;
    b_estart = block_start ? OFF_W'(16) : entry_start;
    b_win    = block_start ? '0 : byte_window;
    b_ha     = block_start ? '0 : held_wide_a;
    b_hb     = block_start ? '0 : held_wide_b;
    b_hn     = block_start ? '0 : held_narrow;
    active   = block_start || phase == PH_HEAD || phase == PH_WALK;

    byte_offset_next  = byte_offset;
    block_total_next  = block_total;
    tag_start_next    = tag_start;
    tag_type_next     = tag_type;
    tag_size_next     = tag_size;
    entry_stride_next = entry_stride;
    entry_start_next  = entry_start;
    byte_window_next  = byte_window;
    held_wide_a_next  = held_wide_a;
    held_wide_b_next  = held_wide_b;
    held_narrow_next  = held_narrow;
    phase_next        = phase;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    er = '0;
    done = 1'b0;
    do_end = 1'b0;
    size_eff = b_tsize;

    byte_window_next = {data_byte, b_win[63:8]};
    hi   = byte_window_next[63:32];
    rel  = b_off - b_tstart;
    rel32 = {11'd0, rel};
    erel = rel - b_estart;
    entry_end = {12'd0, b_estart} + {1'b0, b_stride};
    oem = {byte_window_next[23:16], byte_window_next[31:24], byte_window_next[39:32],
           byte_window_next[47:40], byte_window_next[55:48], byte_window_next[63:56]};
    end_next = ({13'd0, b_tstart} + {2'd0, hi} + 34'd7) & ~34'd7;

    if (active) begin
      if (block_start) begin
        block_total_next  = b_total;
        tag_start_next    = b_tstart;
        tag_type_next     = b_ttype;
        tag_size_next     = b_tsize;
        entry_stride_next = b_stride;
        entry_start_next  = b_estart;
        held_wide_a_next  = b_ha;
        held_wide_b_next  = b_hb;
        held_narrow_next  = b_hn;
        phase_next        = PH_HEAD;
      end
      if (!block_start && phase == PH_HEAD || block_start) begin
        // Header: total size at byte 3, walk starts after byte 7
        if (b_off == OFF_W'(3)) begin
          if (hi < 32'd16 || hi > 32'(MAX_TOTAL)) begin
            er = mk_rec(KIND_FINAL, '0, '0, '0, '0, '0, '0, ST_TOTAL);
            done = 1'b1;
          end else begin
            block_total_next = hi[OFF_W-1:0];
            er = mk_rec(KIND_TOTAL, {32'd0, hi}, '0, '0, '0, '0, '0, ST_PASS);
          end
          r0 = er;
          n = 2'd1;
        end else if (b_off >= OFF_W'(7)) begin
          phase_next = PH_WALK;
          tag_start_next = OFF_W'(8);
        end
      end else if (b_off >= b_tstart) begin
        if (rel == OFF_W'(3)) begin
          tag_type_next = hi;
        end else if (rel == OFF_W'(7)) begin
          // Tag header: bound check, header record, size checks
          tag_size_next = hi;
          size_eff = hi;
          if (hi < 32'd8 || hi > {11'd0, b_total - b_tstart}) begin
            r0 = mk_rec(KIND_FINAL, '0, '0, '0, '0, '0, '0, ST_BOUNDS);
            n = 2'd1;
            done = 1'b1;
          end else begin
            r0 = mk_rec(KIND_TAG, {32'd0, b_ttype}, {32'd0, hi}, '0, '0, '0, '0,
                        ST_PASS);
            n = 2'd1;
            if (b_ttype == TAG_END) begin
              r1 = mk_rec(KIND_FINAL, '0, '0, '0, '0, '0, '0,
                          (hi != 32'd8 || end_next != {13'd0, b_total}) ?
                          ST_ENDLAST : ST_PASS);
              n = 2'd2;
              done = 1'b1;
            end else if (b_ttype == TAG_MMAP && hi < 32'd16) begin
              r1 = mk_rec(KIND_FINAL, '0, '0, '0, '0, '0, '0, ST_MMAP);
              n = 2'd2;
              done = 1'b1;
            end else if ((b_ttype == TAG_RSDP1 || b_ttype == TAG_RSDP2) &&
                         (hi < 32'd28 || (b_ttype == TAG_RSDP2 && hi < 32'd44))) begin
              r1 = mk_rec(KIND_FINAL, '0, '0, '0, '0, '0, '0, ST_ACPI);
              n = 2'd2;
              done = 1'b1;
            end else if (b_ttype == TAG_FB && hi < 32'd32) begin
              r1 = mk_rec(KIND_FINAL, '0, '0, '0, '0, '0, '0, ST_FB);
              n = 2'd2;
              done = 1'b1;
            end else if (hi == 32'd8) begin
              do_end = 1'b1;
            end
          end
        end else if (rel > OFF_W'(7) && rel32 < b_tsize) begin
          // Tag body fields
          if (b_ttype == TAG_MMAP) begin
            if (rel == OFF_W'(11)) begin
              entry_stride_next = hi;
              if (hi < 32'd24) begin
                r0 = mk_rec(KIND_FINAL, '0, '0, '0, '0, '0, '0, ST_MMAP);
                n = 2'd1;
                done = 1'b1;
              end
            end else if (rel >= b_estart && entry_end <= {1'b0, b_tsize}) begin
              if (erel == OFF_W'(7)) begin
                held_wide_a_next = byte_window_next;
              end else if (erel == OFF_W'(15)) begin
                held_wide_b_next = byte_window_next;
              end else if (erel == OFF_W'(19)) begin
                r0 = mk_rec(KIND_MMAP, b_ha, b_hb, hi, '0, '0, '0, ST_PASS);
                n = 2'd1;
                entry_start_next = entry_end[OFF_W-1:0];
              end
            end
          end else if (b_ttype == TAG_RSDP1 || b_ttype == TAG_RSDP2) begin
            if (rel == OFF_W'(22)) begin
              held_wide_a_next = {16'd0, oem};
            end else if (rel == OFF_W'(23)) begin
              held_narrow_next = {24'd0, byte_window_next[63:56]};
            end else if (rel == OFF_W'(27)) begin
              if (b_ttype == TAG_RSDP1) begin
                r0 = mk_rec(KIND_ACPI, b_ha, '0, hi, '0, b_hn[7:0], '0, ST_PASS);
                n = 2'd1;
              end else begin
                held_wide_b_next = {32'd0, hi};
              end
            end else if (rel == OFF_W'(39) && b_ttype == TAG_RSDP2) begin
              r0 = mk_rec(KIND_ACPI, b_ha, byte_window_next, b_hb[31:0], '0,
                          b_hn[7:0], '0, ST_PASS);
              n = 2'd1;
            end
          end else if (b_ttype == TAG_FB) begin
            if (rel == OFF_W'(15)) begin
              held_wide_a_next = byte_window_next;
            end else if (rel == OFF_W'(19)) begin
              held_narrow_next = hi;
            end else if (rel == OFF_W'(27)) begin
              held_wide_b_next = byte_window_next;
            end else if (rel == OFF_W'(29)) begin
              r0 = mk_rec(KIND_FB, b_ha, {32'd0, b_hn}, b_hb[31:0], b_hb[63:32],
                          byte_window_next[55:48], byte_window_next[63:56], ST_PASS);
              n = 2'd1;
            end
          end
          if (!done && rel32 == b_tsize - 32'd1) begin
            do_end = 1'b1;
          end
        end
      end

      // Tag end: step to the next aligned tag or report a wrapped size or a missing end tag
      next_tag = ({13'd0, b_tstart} + {2'd0, size_eff} + 34'd7) & ~34'd7;
      if (do_end) begin
        if (next_tag <= {13'd0, b_tstart}) begin
          er = mk_rec(KIND_FINAL, '0, '0, '0, '0, '0, '0, ST_SMALL);
          done = 1'b1;
        end else if (next_tag + 34'd8 > {13'd0, b_total}) begin
          er = mk_rec(KIND_FINAL, '0, '0, '0, '0, '0, '0, ST_NOEND);
          done = 1'b1;
        end else begin
          tag_start_next = next_tag[OFF_W-1:0];
          entry_start_next = OFF_W'(16);
        end
        if (done) begin
          if (n == 2'd0) begin
            r0 = er;
          end else begin
            r1 = er;
          end
          n = n + 2'd1;
        end
      end
      if (done) begin
        phase_next = PH_DONE;
      end
      byte_offset_next = b_off + OFF_W'(1);
    end else begin
      byte_window_next = byte_window;
      next_tag = '0;
    end

    // Mark the last record of this byte
    if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      r0.last_of_run = 1'b1;
    end
    push.count = accept ? n : 2'd0;
    push.rec0 = r0;
    push.rec1 = r1;
  end

  // Advance walk state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      block_total  <= '0;
      tag_start    <= OFF_W'(8);
      tag_type     <= '0;
      tag_size     <= '0;
      entry_stride <= '0;
      entry_start  <= OFF_W'(16);
      byte_window  <= '0;
      held_wide_a  <= '0;
      held_wide_b  <= '0;
      held_narrow  <= '0;
      phase        <= PH_WAIT;
    end else if (accept) begin
      byte_offset  <= byte_offset_next;
      block_total  <= block_total_next;
      tag_start    <= tag_start_next;
      tag_type     <= tag_type_next;
      tag_size     <= tag_size_next;
      entry_stride <= entry_stride_next;
      entry_start  <= entry_start_next;
      byte_window  <= byte_window_next;
      held_wide_a  <= held_wide_a_next;
      held_wide_b  <= held_wide_b_next;
      held_narrow  <= held_narrow_next;
      phase        <= phase_next;
    end
  end
endmodule
`default_nettype wire

@@ sv/bitw_queue.sv @@
// Four-entry record queue: up to two pushes and one pop per cycle.
`default_nettype none
module bitw_queue
  import bitw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  push_t      push,
  input  wire logic  pop,
  output rec_t       head,
  output qstat_t     stat
);
  rec_t       slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] level, level_next;

  assign head = slots[rd_ptr];
  assign stat.level = level;
  assign stat.room = level <= 3'd2;
  assign level_next = level + {1'b0, push.count} - {2'd0, pop};

  // Store pushed records
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.rec0;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + 2'd1] <= push.rec1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      level  <= level_next;
    end
  end
endmodule
`default_nettype wire

@@ sv/boot_info_tag_walker.sv @@
// Latency: records of a byte can be taken from the cycle after its transfer.
// Throughput: one byte per cycle; a byte causes up to two records, drained
// one per cycle while the record side is ready, from a four-entry queue, so input stalls
// only when the queue cannot take two more. Synchronous reset empties the queue and waits for a
// byte that marks a block start.
`default_nettype none
`include "assert_macros.svh"
module boot_info_tag_walker
  import bitw_pkg::*;
#(
  parameter int MAX_TOTAL = 1048576
) (
  input wire logic clk,
  input wire logic rst,
  bitw_byte_if.sink in_ch,
  bitw_rec_if.source out_ch
);
  push_t  push;
  rec_t   head;
  qstat_t stat;
  logic   accept, pop;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop = out_ch.valid && out_ch.ready;
  assign in_ch.ready = stat.room;

  bitw_core #(.MAX_TOTAL(MAX_TOTAL)) u_core (
    .clk(clk), .rst(rst), .accept(accept), .data_byte(in_ch.data_byte),
    .block_start(in_ch.block_start), .push(push)
  );

  bitw_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .pop(pop), .head(head), .stat(stat)
  );

  // Drive the record channel from the queue head
  assign out_ch.valid = stat.level != 3'd0;
  assign out_ch.record_kind = head.record_kind;
  assign out_ch.value_a = head.value_a;
  assign out_ch.value_b = head.value_b;
  assign out_ch.value_c = head.value_c;
  assign out_ch.value_d = head.value_d;
  assign out_ch.value_e = head.value_e;
  assign out_ch.value_f = head.value_f;
  assign out_ch.status = head.status;
  assign out_ch.last_of_run = head.last_of_run;

  `ASSERT_ALWAYS(a_level_max, clk, rst, stat.level <= 3'd4, "queue level over depth")
  `ASSERT_IMPLY(a_push_room, clk, rst, push.count != 2'd0, in_ch.ready, "push without room")
  `ASSERT_IMPLY(a_last_pair, clk, rst, push.count == 2'd2, push.rec1.last_of_run && !push.rec0.last_of_run, "bad last mark")
endmodule
`default_nettype wire

@@ tb/boot_info_tag_walker_tb.sv @@
// Testbench for the boot information tag walker: byte stream in, checked records out.
`timescale 1ns / 1ps
`default_nettype none
module boot_info_tag_walker_tb;
  import bitw_pkg::*;

  localparam int MAX_TOTAL_BYTES = 1048576;
  localparam int ITEM_TARGET = 1300;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum logic [1:0] {PH_IDLE, PH_HDR, PH_TAGS, PH_OVER} walk_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  bitw_byte_if in_if ();
  bitw_rec_if out_if ();

  boot_info_tag_walker #(.MAX_TOTAL(MAX_TOTAL_BYTES)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_if.sink), .out_ch(out_if.source)
  );

  // Walker state mirror
  logic [31:0]  w_off, w_total, w_tag_start, w_tag_type, w_tag_size;
  logic [31:0]  w_stride, w_entry_start, w_narrow;
  logic [63:0]  w_window, w_wide_a, w_wide_b;
  walk_phase_t  w_phase;

  rec_t expected_recs[$];
  rec_t step_recs[$];
  int   error_count = 0;
  int   bytes_sent = 0;
  int   recs_seen = 0;
  int   blocks_sent = 0;
  int   cycle_count = 0;
  bit   quiet = 1'b0;
  int   hold_cycles = 0;
  logic [7:0] blk[$];

  task automatic clear_walk();
    w_off = 0; w_total = 0; w_tag_start = 8; w_tag_type = 0; w_tag_size = 0;
    w_stride = 0; w_entry_start = 16; w_window = '0; w_wide_a = '0; w_wide_b = '0;
    w_narrow = 0; w_phase = PH_IDLE;
  endtask

  task automatic add_rec(logic [2:0] kind, logic [63:0] a, logic [63:0] b,
                         logic [31:0] c, logic [31:0] d, logic [7:0] e,
                         logic [7:0] f, logic [3:0] st);
    rec_t r;
    if (step_recs.size() >= 2) return;
    r.record_kind = kind; r.value_a = a; r.value_b = b; r.value_c = c;
    r.value_d = d; r.value_e = e; r.value_f = f; r.status = st; r.last_of_run = 1'b0;
    step_recs.push_back(r);
  endtask

  task automatic finish_walk(logic [3:0] st);
    add_rec(KIND_FINAL, '0, '0, '0, '0, '0, '0, st);
    w_phase = PH_OVER;
  endtask

  // Advance to the next 8-aligned tag or conclude
  task automatic close_tag();
    logic [31:0] nxt;
    nxt = (w_tag_start + w_tag_size + 32'd7) & ~32'd7;
    if (nxt <= w_tag_start) begin
      finish_walk(ST_SMALL);
    end else if ({32'd0, nxt} + 64'd8 > {32'd0, w_total}) begin
      finish_walk(ST_NOEND);
    end else begin
      w_tag_start = nxt & 32'h1FFFFF;
      w_entry_start = 16;
    end
  endtask

  task automatic walk_tag_byte(logic [31:0] o);
    logic [31:0] r, hi, e, nxt;
    hi = w_window[63:32];
    if (o < w_tag_start) return;
    r = o - w_tag_start;
    if (r == 3) begin
      w_tag_type = hi;
      return;
    end
    if (r < 7) return;
    if (r == 7) begin
      w_tag_size = hi;
      if (w_tag_size < 8 || w_tag_size > w_total - w_tag_start) begin
        finish_walk(ST_BOUNDS);
        return;
      end
      add_rec(KIND_TAG, {32'd0, w_tag_type}, {32'd0, w_tag_size}, '0, '0, '0, '0, ST_PASS);
      if (w_tag_type == TAG_END) begin
        nxt = (w_tag_start + w_tag_size + 32'd7) & ~32'd7;
        finish_walk((w_tag_size != 8 || nxt != w_total) ? ST_ENDLAST : ST_PASS);
        return;
      end
      if (w_tag_type == TAG_MMAP && w_tag_size < 16) begin
        finish_walk(ST_MMAP);
        return;
      end
      if ((w_tag_type == TAG_RSDP1 || w_tag_type == TAG_RSDP2) &&
          (w_tag_size < 28 || (w_tag_type == TAG_RSDP2 && w_tag_size < 44))) begin
        finish_walk(ST_ACPI);
        return;
      end
      if (w_tag_type == TAG_FB && w_tag_size < 32) begin
        finish_walk(ST_FB);
        return;
      end
      if (w_tag_size == 8) close_tag();
      return;
    end
    if (r >= w_tag_size) return;
    if (w_tag_type == TAG_MMAP) begin
      if (r == 11) begin
        w_stride = hi;
        if (w_stride < 24) begin
          finish_walk(ST_MMAP);
          return;
        end
      end else if (r >= w_entry_start &&
                   {1'b0, w_entry_start} + {1'b0, w_stride} <= {1'b0, w_tag_size}) begin
        e = r - w_entry_start;
        if (e == 7) w_wide_a = w_window;
        else if (e == 15) w_wide_b = w_window;
        else if (e == 19) begin
          add_rec(KIND_MMAP, w_wide_a, w_wide_b, hi, '0, '0, '0, ST_PASS);
          w_entry_start = (w_entry_start + w_stride) & 32'h1FFFFF;
        end
      end
    end else if (w_tag_type == TAG_RSDP1 || w_tag_type == TAG_RSDP2) begin
      if (r == 22) begin
        w_wide_a = {16'd0, w_window[23:16], w_window[31:24], w_window[39:32],
                    w_window[47:40], w_window[55:48], w_window[63:56]};
      end else if (r == 23) begin
        w_narrow = {24'd0, w_window[63:56]};
      end else if (r == 27) begin
        if (w_tag_type == TAG_RSDP1)
          add_rec(KIND_ACPI, w_wide_a, '0, hi, '0, w_narrow[7:0], '0, ST_PASS);
        else
          w_wide_b = {32'd0, hi};
      end else if (r == 39 && w_tag_type == TAG_RSDP2) begin
        add_rec(KIND_ACPI, w_wide_a, w_window, w_wide_b[31:0], '0, w_narrow[7:0], '0,
                ST_PASS);
      end
    end else if (w_tag_type == TAG_FB) begin
      if (r == 15) w_wide_a = w_window;
      else if (r == 19) w_narrow = hi;
      else if (r == 27) w_wide_b = w_window;
      else if (r == 29)
        add_rec(KIND_FB, w_wide_a, {32'd0, w_narrow}, w_wide_b[31:0], w_wide_b[63:32],
                w_window[55:48], w_window[63:56], ST_PASS);
    end
    if (w_phase == PH_TAGS && r == w_tag_size - 32'd1) close_tag();
  endtask

  // Work out the records caused by one accepted byte
  task automatic predict_byte(logic [7:0] b, logic s);
    logic [31:0] o, t;
    step_recs.delete();
    if (s) begin
      clear_walk();
      w_phase = PH_HDR;
    end else if (w_phase == PH_IDLE || w_phase == PH_OVER) begin
      return;
    end
    w_window = {b, w_window[63:8]};
    o = w_off;
    if (w_phase == PH_HDR) begin
      if (o == 3) begin
        t = w_window[63:32];
        if (t < 16 || t > MAX_TOTAL_BYTES) finish_walk(ST_TOTAL);
        else begin
          w_total = t;
          add_rec(KIND_TOTAL, {32'd0, t}, '0, '0, '0, '0, '0, ST_PASS);
        end
      end else if (o >= 7) begin
        w_phase = PH_TAGS;
        w_tag_start = 8;
      end
    end else begin
      walk_tag_byte(o);
    end
    w_off = (o + 1) & 32'h1FFFFF;
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last_of_run = 1'b1;
    foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
  endtask

  // Send one byte and wait for its transfer
  task automatic send_byte(logic [7:0] b, logic s);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.block_start <= s;
    do @(posedge clk); while (!in_if.ready);
    predict_byte(b, s);
    bytes_sent++;
  endtask

  task automatic send_block();
    foreach (blk[i]) send_byte(blk[i], i == 0);
    blocks_sent++;
  endtask

  // Drop valid at once so the last byte is not taken twice
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Block builders
  task automatic put32(logic [31:0] v);
    for (int i = 0; i < 4; i++) blk.push_back(v[8*i +: 8]);
  endtask

  task automatic put_rand(int n);
    for (int i = 0; i < n; i++) blk.push_back(8'($urandom));
  endtask

  task automatic pad8();
    while (blk.size() % 8 != 0) blk.push_back(8'($urandom));
  endtask

  task automatic set_total(logic [31:0] v);
    for (int i = 0; i < 4; i++) blk[i] = v[8*i +: 8];
  endtask

  task automatic start_block();
    blk.delete();
    put32(32'd0);
    put_rand(4);
  endtask

  task automatic add_mmap(int stride, int entries, int extra);
    put32(TAG_MMAP);
    put32(32'(16 + stride * entries + extra));
    put32(32'(stride));
    put32($urandom);
    put_rand(stride * entries + extra);
    pad8();
  endtask

  task automatic add_simple(logic [31:0] kind, int size);
    put32(kind);
    put32(32'(size));
    put_rand(size - 8);
    pad8();
  endtask

  task automatic add_end();
    put32(TAG_END);
    put32(32'd8);
  endtask

  task automatic add_random_tag();
    case ($urandom_range(0, 5))
      0: add_mmap(24 + 8 * $urandom_range(0, 2), $urandom_range(1, 3), $urandom_range(0, 5));
      1: add_simple(TAG_RSDP1, 28 + $urandom_range(0, 4));
      2: add_simple(TAG_RSDP2, 44 + $urandom_range(0, 4));
      3: add_simple(TAG_FB, 32 + $urandom_range(0, 6));
      4: add_simple(32'($urandom_range(1, 21)), $urandom_range(8, 24));
      default: add_simple($urandom, $urandom_range(8, 16));
    endcase
  endtask

  task automatic build_good(int tags);
    start_block();
    repeat (tags) add_random_tag();
    add_end();
    set_total(blk.size());
  endtask

  // Directed tests
  task automatic test_bad_totals();
    start_block(); add_end(); set_total(32'd15); send_block();
    start_block(); add_end(); set_total(32'h00100001); send_block();
    start_block(); add_end(); set_total(32'hFFFFFFFF); send_block();
    start_block(); add_end(); set_total(32'd0); send_block();
    wait_drained();
  endtask

  task automatic test_min_and_max_blocks();
    start_block(); add_end(); set_total(32'd16); send_block();
    start_block(); add_end(); set_total(32'h00100000); send_block();
    wait_drained();
  endtask

  task automatic test_idle_bytes();
    repeat (6) send_byte(8'($urandom), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    build_good(1); send_block();
    repeat (6) send_byte(8'($urandom), 1'b0);
    wait_drained();
  endtask

  task automatic test_size_failures();
    start_block(); add_mmap(24, 1, 0); blk[blk.size() - 36] = 8'd12; add_end();
    set_total(blk.size()); send_block();
    start_block(); add_mmap(16, 1, 0); add_end(); set_total(blk.size()); send_block();
    start_block(); add_simple(TAG_RSDP1, 20); add_end(); set_total(blk.size()); send_block();
    start_block(); add_simple(TAG_RSDP2, 30); add_end(); set_total(blk.size()); send_block();
    start_block(); add_simple(TAG_FB, 20); add_end(); set_total(blk.size()); send_block();
    start_block(); put32(32'd1); put32(32'd4); put_rand(8); add_end();
    set_total(blk.size()); send_block();
    start_block(); put32(32'd1); put32(32'h7FFFFFFF); put_rand(8); add_end();
    set_total(blk.size()); send_block();
    wait_drained();
  endtask

  task automatic test_end_placement();
    // end tag followed by more data, end tag too long, end tag missing
    start_block(); add_end(); put_rand(8); set_total(blk.size()); send_block();
    start_block(); put32(TAG_END); put32(32'd16); put_rand(8); set_total(blk.size());
    send_block();
    start_block(); add_simple(32'd2, 13); set_total(blk.size()); send_block();
    start_block(); add_simple(32'd2, 13); put_rand(7); set_total(blk.size()); send_block();
    wait_drained();
  endtask

  task automatic test_restart();
    build_good(3);
    for (int i = 0; i < blk.size() / 2; i++) send_byte(blk[i], i == 0);
    build_good(2); send_block();
    wait_drained();
  endtask

  task automatic test_every_tag_kind();
    start_block();
    add_mmap(24, 3, 3); add_mmap(40, 2, 0);
    add_simple(TAG_RSDP1, 28); add_simple(TAG_RSDP2, 44);
    add_simple(TAG_FB, 32); add_simple(TAG_FB, 37); add_simple(32'd3, 9);
    add_end(); set_total(blk.size()); send_block();
    wait_drained();
  endtask

  // Stall the record side long enough to back the input up
  task automatic test_backpressure();
    build_good(5);
    hold_cycles = 150;
    quiet = 1'b1;
    send_block();
    quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_blocks();
    int pick, cut, pos;
    while (bytes_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 7) == 0);
      build_good($urandom_range(1, 5));
      pick = $urandom_range(0, 9);
      if (pick == 7) begin
        pos = $urandom_range(0, blk.size() - 1);
        blk[pos] = blk[pos] ^ 8'(1 << $urandom_range(0, 7));
      end else if (pick == 8) begin
        cut = $urandom_range(1, blk.size() - 1);
        repeat (cut) void'(blk.pop_back());
      end else if (pick == 9) begin
        set_total(blk.size() + 8 * $urandom_range(0, 2) - 4 * $urandom_range(0, 2));
      end
      send_block();
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    quiet = 1'b0;
    wait_drained();
  endtask

  // Record side ready pattern
  initial begin
    int w;
    out_if.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = quiet ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Check each record transfer against the oldest expectation
  always @(posedge clk) begin
    rec_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      recs_seen++;
      if (expected_recs.size() == 0) begin
        $display("%0t: unexpected record kind %0d, expected none", $time,
                 out_if.record_kind);
        error_count++;
      end else begin
        want = expected_recs.pop_front();
        cmp_field("record_kind", 64'(want.record_kind), 64'(out_if.record_kind));
        cmp_field("value_a", want.value_a, out_if.value_a);
        cmp_field("value_b", want.value_b, out_if.value_b);
        cmp_field("value_c", 64'(want.value_c), 64'(out_if.value_c));
        cmp_field("value_d", 64'(want.value_d), 64'(out_if.value_d));
        cmp_field("value_e", 64'(want.value_e), 64'(out_if.value_e));
        cmp_field("value_f", 64'(want.value_f), 64'(out_if.value_f));
        cmp_field("status", 64'(want.status), 64'(out_if.status));
        cmp_field("last_of_run", 64'(want.last_of_run), 64'(out_if.last_of_run));
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d records outstanding", $time, expected_recs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.block_start <= 1'b0;
    clear_walk();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_bad_totals();
    test_min_and_max_blocks();
    test_idle_bytes();
    test_size_failures();
    test_end_placement();
    test_restart();
    test_every_tag_kind();
    test_backpressure();
    test_random_blocks();
    if (expected_recs.size() != 0) begin
      $display("%0t: %0d expected records never arrived", $time, expected_recs.size());
      error_count++;
    end
    $display("Walked %0d blocks over %0d bytes, %0d records checked.", blocks_sent,
             bytes_sent, recs_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
